// ===== hw/rtl/ssc_pkg.sv =====
`default_nettype none
package ssc_pkg;

  localparam int unsigned MAX_STAMPS_DEF = 1024;
  localparam int unsigned LIMIT_W        = 48;
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned COUNT_OUT_W    = 11;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [16:0] COV_FULL = 17'h1_0000;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PREFIX = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SUFFIX = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP    = 2'd2;

  // verdict codes
  localparam logic [2:0] RSN_OK      = 3'd0;
  localparam logic [2:0] RSN_INVALID = 3'd1;
  localparam logic [2:0] RSN_EMPTY   = 3'd2;
  localparam logic [2:0] RSN_PREFIX  = 3'd3;
  localparam logic [2:0] RSN_SUFFIX  = 3'd4;
  localparam logic [2:0] RSN_GAP     = 3'd5;

  typedef struct packed {
    logic signed [63:0] window_start_ns;
    logic signed [63:0] window_end_ns;
    logic signed [63:0] stamp_ns;
    logic               stamp_present;
    logic               last_item;
  } ssc_in_t;

  typedef struct packed {
    logic [10:0]        stamp_count;
    logic signed [63:0] missing_prefix_ns;
    logic signed [63:0] missing_suffix_ns;
    logic [62:0]        widest_gap_ns;
    logic [16:0]        cover_frac_q16;
    logic               health;
    logic [2:0]         reason;
    logic               overflow;
  } ssc_out_t;

  // signed a - b, saturated to the int64 range
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if ((a[63] ^ b[63]) && (a[63] ^ d[63])) begin
      sat_sub = a[63] ? S64_MIN : S64_MAX;
    end else begin
      sat_sub = d;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssc_ram.sv =====
`default_nettype none
module ssc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ssc_qdiv.sv =====
`default_nettype none
// floor(num * 2^16 / den) for num < den, one quotient bit per cycle
module ssc_qdiv
  import ssc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [15:0]      quot
);
  logic [63:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [64:0] sh;

  assign sh   = {rem_r, 1'b0};
  assign done = run_r && (cnt_r == 5'd15);
  assign quot = q_nxt;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      rem_nxt = num;
      q_nxt   = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= {1'b0, den}) begin
        rem_nxt = 64'(sh - {1'b0, den});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sensor_stamp_coverage_check_core.sv =====
`default_nettype none
// Timestamp coverage checker for one scan window. Items are taken when start
// is high and busy is low; each present stamp is insertion-sorted into the
// stamp RAM as it arrives, walking down from the top entry one RAM read per
// cycle and moving each stored stamp larger than it up one entry; an item
// without a stamp, the first stamp of a window or a stamp dropped at capacity
// needs no walk. On the last item an invalid window or one with no stamps gets
// its verdict from the check state; else the sorted RAM is scanned once for
// first, last and largest gap, then a setup state and, unless the stamps span
// the whole window, a bit-serial divider forms the Q1.16 coverage, and a
// verdict state follows. The result is shown for exactly one cycle on
// out_valid and must be taken then: there is no way to stall it. Config
// writes apply at once and are meant for idle time only.
module sensor_stamp_coverage_check_core
  import ssc_pkg::*;
#(
  parameter int unsigned MAX_STAMPS = MAX_STAMPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ssc_in_t               in_item,
  output logic                       out_valid,
  output ssc_out_t                   out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata
);
  localparam int unsigned AW = $clog2(MAX_STAMPS);
  localparam int unsigned CW = $clog2(MAX_STAMPS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_STAMPS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INS   = 9'b000000010,  // insertion walk
    S_INSW  = 9'b000000100,  // key lands at entry zero
    S_CHK   = 9'b000001000,  // window / empty decision
    S_SCAN  = 9'b000010000,  // sorted walk for first, last, gap
    S_DIV0  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_VERD  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LIMIT_W-1:0] lim_pre_r, lim_suf_r, lim_gap_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               drop_r, drop_nxt;
  logic               last_r, last_nxt;
  logic [63:0]        st_r, st_nxt, en_r, en_nxt, key_r, key_nxt;
  logic [63:0]        first_r, first_nxt, prev_r, prev_nxt, gap_r, gap_nxt;
  logic [63:0]        pre_r, pre_nxt, suf_r, suf_nxt;
  logic [16:0]        cov_r, cov_nxt;
  logic               ov_r, ov_nxt;
  ssc_out_t           res_r, res_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [63:0]        wdata, rdata;
  logic               div_start, div_done;
  logic [15:0]        div_q;
  logic [63:0]        diff, dur, covered;
  logic               fin;

  ssc_ram #(.WIDTH(64), .DEPTH(MAX_STAMPS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign dur     = en_r - st_r;
  assign covered = prev_r - first_r;
  assign diff    = rdata - prev_r;

  ssc_qdiv u_div (
    .clk, .rst_n, .start(div_start), .num(covered), .den(dur),
    .done(div_done), .quot(div_q)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = res_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    drop_nxt  = drop_r;
    last_nxt  = last_r;
    st_nxt    = st_r;
    en_nxt    = en_r;
    key_nxt   = key_r;
    first_nxt = first_r;
    prev_nxt  = prev_r;
    gap_nxt   = gap_r;
    pre_nxt   = pre_r;
    suf_nxt   = suf_r;
    cov_nxt   = cov_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = key_r;
    raddr     = '0;
    div_start = 1'b0;
    fin       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt   = in_item.window_start_ns;
          en_nxt   = in_item.window_end_ns;
          key_nxt  = in_item.stamp_ns;
          last_nxt = in_item.last_item;
          state_nxt = in_item.last_item ? S_CHK : S_IDLE;
          if (in_item.stamp_present) begin
            if (cnt_r == CNT_MAX) begin
              drop_nxt = 1'b1;
            end else if (cnt_r == '0) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = in_item.stamp_ns;
              cnt_nxt = CW'(1);
            end else begin
              raddr     = AW'(cnt_r - CW'(1));
              j_nxt     = AW'(cnt_r);
              state_nxt = S_INS;
            end
          end
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = j_r;
        if ($signed(key_r) < $signed(rdata)) begin
          wdata = rdata;
          j_nxt = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = S_INSW;
          end else begin
            raddr = j_r - AW'(2);
          end
        end else begin
          wdata     = key_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = last_r ? S_CHK : S_IDLE;
        end
      end
      S_INSW: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = key_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = last_r ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        res_nxt          = '0;
        res_nxt.health   = 1'b1;
        res_nxt.overflow = drop_r;
        gap_nxt          = '0;
        if (!($signed(st_r) < $signed(en_r))) begin
          res_nxt.reason = RSN_INVALID;
          fin            = 1'b1;
        end else if (cnt_r == '0) begin
          res_nxt.reason            = RSN_EMPTY;
          res_nxt.missing_prefix_ns = dur[63] ? S64_MAX : dur;
          res_nxt.missing_suffix_ns = dur[63] ? S64_MAX : dur;
          fin                       = 1'b1;
        end else begin
          raddr     = '0;
          idx_nxt   = CW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        prev_nxt = rdata;
        if (idx_r == CW'(1)) begin
          first_nxt = rdata;
        end else if (diff > gap_r) begin
          gap_nxt = diff;
        end
        if (idx_r == cnt_r) begin
          state_nxt = S_DIV0;
        end else begin
          raddr   = AW'(idx_r);
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DIV0: begin
        pre_nxt = sat_sub(first_r, st_r);
        suf_nxt = sat_sub(en_r, prev_r);
        if (covered >= dur) begin
          cov_nxt   = COV_FULL;
          state_nxt = S_VERD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cov_nxt   = {1'b0, div_q};
          state_nxt = S_VERD;
        end
      end
      S_VERD: begin
        res_nxt.stamp_count       = COUNT_OUT_W'(cnt_r);
        res_nxt.missing_prefix_ns = pre_r;
        res_nxt.missing_suffix_ns = suf_r;
        res_nxt.widest_gap_ns     = gap_r[63] ? S64_MAX[62:0] : gap_r[62:0];
        res_nxt.cover_frac_q16    = cov_r;
        res_nxt.health            = 1'b1;
        if (!pre_r[63] && (pre_r > {16'b0, lim_pre_r})) begin
          res_nxt.reason = RSN_PREFIX;
        end else if (!suf_r[63] && (suf_r > {16'b0, lim_suf_r})) begin
          res_nxt.reason = RSN_SUFFIX;
        end else if (gap_r > {16'b0, lim_gap_r}) begin
          res_nxt.reason = RSN_GAP;
        end else begin
          res_nxt.reason = RSN_OK;
          res_nxt.health = 1'b0;
        end
        fin = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      ov_nxt    = 1'b1;
      cnt_nxt   = '0;
      drop_nxt  = 1'b0;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      ov_r      <= 1'b0;
      st_r      <= '0;
      en_r      <= '0;
      lim_pre_r <= '0;
      lim_suf_r <= '0;
      lim_gap_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      st_r    <= st_nxt;
      en_r    <= en_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_PREFIX: lim_pre_r <= cfg_wdata;
          REG_SUFFIX: lim_suf_r <= cfg_wdata;
          REG_GAP:    lim_gap_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
    j_r     <= j_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    key_r   <= key_nxt;
    first_r <= first_nxt;
    prev_r  <= prev_nxt;
    gap_r   <= gap_nxt;
    pre_r   <= pre_nxt;
    suf_r   <= suf_nxt;
    cov_r   <= cov_nxt;
    res_r   <= res_nxt;
  end

  // stored count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("stamp count over capacity");

  // a result leaves the block idle with an empty store
  a_res_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && cnt_r == '0 && !drop_r))
    else $error("result without clearing");

  // the health flag is low only for a clean verdict
  a_health: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.health == (out_item.reason != RSN_OK)))
    else $error("health and reason disagree");

  // results come only from the final sequencing states
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_CHK || $past(state_r) == S_VERD))
    else $error("result from unexpected state");
endmodule
`default_nettype wire

// ===== bench/sensor_stamp_coverage_check_core_tb.sv =====
module sensor_stamp_coverage_check_core_tb;
  import ssc_pkg::*;

  localparam int unsigned DEPTH = MAX_STAMPS_DEF;
  // worst case for one item: a full walk of the stamp RAM plus the final scan
  localparam int unsigned DRAIN = 2 * DEPTH + 64;

  // Predicts the window verdict on each last item and checks results in order.
  class stamp_scoreboard;
    logic [63:0]      store[DEPTH];
    int unsigned      cnt;
    logic             dropped;
    logic [63:0]      win_lo, win_hi;
    logic [47:0]      lim_prefix, lim_suffix, lim_gap;
    ssc_out_t         pending_q[$];
    int unsigned      errors, verdicts, windows;
    int unsigned      reason_seen[8];

    function new();
      cnt = 0;
      dropped = 1'b0;
      win_lo = '0;
      win_hi = '0;
      lim_prefix = '0;
      lim_suffix = '0;
      lim_gap = '0;
      errors = 0;
      verdicts = 0;
      windows = 0;
      foreach (reason_seen[k]) reason_seen[k] = 0;
    endfunction

    function void set_limit(logic [CFG_ADDR_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        REG_PREFIX: lim_prefix = val;
        REG_SUFFIX: lim_suffix = val;
        REG_GAP:    lim_gap = val;
        default: ;
      endcase
    endfunction

    // a - b as signed 64-bit, clamped to the int64 range
    function logic [63:0] diff_clamped(logic [63:0] a, logic [63:0] b);
      logic signed [64:0] x;
      x = $signed({a[63], a}) - $signed({b[63], b});
      if (x > $signed({1'b0, S64_MAX})) return S64_MAX;
      if (x < $signed({1'b1, S64_MIN})) return S64_MIN;
      return x[63:0];
    endfunction

    // negative differences never trip a limit
    function bit over_limit(logic [63:0] v, logic [47:0] lim);
      return !v[63] && (v > {16'h0, lim});
    endfunction

    function void note_item(ssc_in_t it);
      ssc_out_t    r;
      logic [63:0] dur, first, last, d, gap, covered, key;
      logic [79:0] q;
      int          i, j;
      win_lo = it.window_start_ns;
      win_hi = it.window_end_ns;
      if (it.stamp_present) begin
        if (cnt < DEPTH) begin
          store[cnt] = it.stamp_ns;
          cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
      if (!it.last_item) return;
      windows++;
      r = '0;
      r.health = 1'b1;
      r.overflow = dropped;
      if (!($signed(win_lo) < $signed(win_hi))) begin
        r.reason = RSN_INVALID;
      end else begin
        dur = win_hi - win_lo;
        if (cnt == 0) begin
          r.missing_prefix_ns = (dur > S64_MAX) ? S64_MAX : dur;
          r.missing_suffix_ns = r.missing_prefix_ns;
          r.reason = RSN_EMPTY;
        end else begin
          for (i = 1; i < cnt; i++) begin
            key = store[i];
            j = i;
            while (j > 0 && $signed(key) < $signed(store[j-1])) begin
              store[j] = store[j-1];
              j--;
            end
            store[j] = key;
          end
          first = store[0];
          last = store[cnt-1];
          gap = '0;
          for (i = 1; i < cnt; i++) begin
            d = store[i] - store[i-1];
            if (d > gap) gap = d;
          end
          if (gap > S64_MAX) gap = S64_MAX;
          covered = last - first;
          q = {covered, 16'h0} / {16'h0, dur};
          r.stamp_count = cnt[10:0];
          r.missing_prefix_ns = diff_clamped(first, win_lo);
          r.missing_suffix_ns = diff_clamped(win_hi, last);
          r.widest_gap_ns = gap[62:0];
          r.cover_frac_q16 = (covered >= dur) ? COV_FULL : q[16:0];
          if (over_limit(r.missing_prefix_ns, lim_prefix)) r.reason = RSN_PREFIX;
          else if (over_limit(r.missing_suffix_ns, lim_suffix)) r.reason = RSN_SUFFIX;
          else if (gap > {16'h0, lim_gap}) r.reason = RSN_GAP;
          else begin
            r.reason = RSN_OK;
            r.health = 1'b0;
          end
        end
      end
      pending_q.push_back(r);
      cnt = 0;
      dropped = 1'b0;
    endfunction

    function void check_verdict(ssc_out_t got);
      ssc_out_t e;
      bit       bad;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result, reason %0d", got.reason);
        return;
      end
      e = pending_q.pop_front();
      verdicts++;
      reason_seen[e.reason]++;
      bad = (got.stamp_count != e.stamp_count) ||
            (got.missing_prefix_ns != e.missing_prefix_ns) ||
            (got.missing_suffix_ns != e.missing_suffix_ns) ||
            (got.widest_gap_ns != e.widest_gap_ns) ||
            (got.cover_frac_q16 != e.cover_frac_q16) ||
            (got.health != e.health) || (got.reason != e.reason) ||
            (got.overflow != e.overflow);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d mismatch", verdicts);
          $display("  exp cnt=%0d pre=%h suf=%h gap=%h cov=%h h=%b rsn=%0d ovf=%b",
                   e.stamp_count, e.missing_prefix_ns, e.missing_suffix_ns,
                   e.widest_gap_ns, e.cover_frac_q16, e.health, e.reason, e.overflow);
          $display("  got cnt=%0d pre=%h suf=%h gap=%h cov=%h h=%b rsn=%0d ovf=%b",
                   got.stamp_count, got.missing_prefix_ns, got.missing_suffix_ns,
                   got.widest_gap_ns, got.cover_frac_q16, got.health, got.reason,
                   got.overflow);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  ssc_in_t               in_item;
  logic                  out_valid;
  ssc_out_t              out_item;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [LIMIT_W-1:0]    cfg_wdata;

  stamp_scoreboard sb;
  int unsigned     items_sent;
  int unsigned     overflow_windows;

  sensor_stamp_coverage_check_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

  // results cannot be held off: every strobe is taken and checked
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_verdict(out_item);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ssc_in_t mk_item(logic [63:0] ws, logic [63:0] we, logic [63:0] st,
                                      logic present, logic last);
    ssc_in_t it;
    it.window_start_ns = ws;
    it.window_end_ns = we;
    it.stamp_ns = st;
    it.stamp_present = present;
    it.last_item = last;
    return it;
  endfunction

  // holds start high until the item is taken (start high, busy low at an edge)
  task automatic send_item(ssc_in_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic sender_gap(int unsigned n);
    start <= 1'b0;
    in_item <= mk_item(rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)), 1'b0);
    repeat (n) @(posedge clk);
  endtask

  // wait for every pending result, then for the block to go quiet
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_limits(logic [LIMIT_W-1:0] p, logic [LIMIT_W-1:0] s,
                              logic [LIMIT_W-1:0] g);
    logic [LIMIT_W-1:0] v[3];
    v[0] = p;
    v[1] = s;
    v[2] = g;
    for (int k = 0; k < 3; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= k[CFG_ADDR_W-1:0];
      cfg_wdata <= v[k];
      @(posedge clk);
      sb.set_limit(k[CFG_ADDR_W-1:0], v[k]);
    end
    // the top index is unmapped and must leave the limits alone
    cfg_addr <= '1;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one window with random shape; mostly well-formed with stamps near the window
  task automatic send_window(int unsigned n, int unsigned idle_pct);
    logic [63:0]  ws, we, span, st;
    logic [39:0]  r40;
    int unsigned  kind;
    logic         present;
    kind = $urandom_range(0, 19);
    r40 = 40'({$urandom, $urandom});
    ws = {{24{r40[39]}}, r40};
    span = 64'($urandom_range(1, 2_000_000));
    we = ws + span;
    if (kind == 0) begin
      ws = rand64();
      we = rand64();
    end else if (kind == 1) begin
      we = ws;
    end else if (kind == 2) begin
      we = ws - span;
    end
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < idle_pct) sender_gap($urandom_range(1, 6));
      present = (kind == 3) ? 1'b0 : ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0:       st = rand64();
        1:       st = ws - $urandom_range(0, 5000);
        2:       st = we + $urandom_range(0, 5000);
        default: st = ws + (span * $urandom_range(0, 1000)) / 1000;
      endcase
      send_item(mk_item(ws, we, st, present, k == n - 1));
    end
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned idle_pct);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      // now and then let the pipe run dry before the next window
      if ($urandom_range(0, 49) == 0) drain();
      send_window(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) :
                  $urandom_range(1, 8), idle_pct);
    end
  endtask

  initial begin
    logic [63:0] base;
    sb = new();
    items_sent = 0;
    overflow_windows = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: limits all zero after reset
    // widest window, stamps at both extremes: gap saturates
    send_item(mk_item(S64_MIN, S64_MAX, S64_MIN, 1'b1, 1'b0));
    send_item(mk_item(S64_MIN, S64_MAX, S64_MAX, 1'b1, 1'b1));
    // widest window with no stamp: empty, duration saturates
    send_item(mk_item(S64_MIN, S64_MAX, '0, 1'b0, 1'b1));
    // end equal to start and end before start: invalid
    send_item(mk_item(64'd100, 64'd100, 64'd100, 1'b1, 1'b1));
    send_item(mk_item(S64_MAX, S64_MIN, 64'd5, 1'b1, 1'b1));
    // stamps outside the window, unsorted: negative prefix and suffix
    send_item(mk_item(64'd1000, 64'd2000, 64'd2500, 1'b1, 1'b0));
    send_item(mk_item(64'd1000, 64'd2000, 64'd500, 1'b1, 1'b0));
    send_item(mk_item(64'd1000, 64'd2000, 64'd1500, 1'b0, 1'b1));
    // single stamp at start
    send_item(mk_item(-64'sd10, 64'd10, -64'sd10, 1'b1, 1'b1));
    // stamp before start far away: prefix saturates negative
    send_item(mk_item(S64_MAX - 1, S64_MAX, S64_MIN, 1'b1, 1'b1));
    // exact edges with a middle stamp: full coverage, gap verdict
    send_item(mk_item(64'd0, 64'd3, 64'd3, 1'b1, 1'b0));
    send_item(mk_item(64'd0, 64'd3, 64'd0, 1'b1, 1'b0));
    send_item(mk_item(64'd0, 64'd3, 64'd1, 1'b1, 1'b1));
    // duplicate stamps equal to both edges: gap of one, gap verdict
    send_item(mk_item(64'd7, 64'd8, 64'd7, 1'b1, 1'b0));
    send_item(mk_item(64'd7, 64'd8, 64'd8, 1'b1, 1'b0));
    send_item(mk_item(64'd7, 64'd8, 64'd7, 1'b1, 1'b1));
    drain();

    // extremes of the limits, then random limits per phase
    write_limits('1, '1, '1);
    send_item(mk_item(S64_MIN, S64_MAX, S64_MIN, 1'b1, 1'b0));
    send_item(mk_item(S64_MIN, S64_MAX, S64_MAX, 1'b1, 1'b1));
    send_item(mk_item(64'd0, 64'd1000, 64'd300, 1'b1, 1'b1));
    drain();

    // phase A: sender idles in 10 of 100 items
    write_limits(LIMIT_W'($urandom_range(0, 300_000)), LIMIT_W'($urandom_range(0, 300_000)),
                 LIMIT_W'($urandom_range(0, 1_000_000)));
    random_phase(250, 10);
    drain();

    // phase B: sender idles in 72 of 100 items
    write_limits(LIMIT_W'($urandom_range(0, 50_000)), '0,
                 LIMIT_W'($urandom_range(0, 500_000)));
    random_phase(250, 72);
    drain();

    // phase C: no idling, plus one window past capacity with ascending stamps
    write_limits(LIMIT_W'({$urandom, $urandom}), LIMIT_W'($urandom_range(0, 500_000)),
                 LIMIT_W'($urandom_range(0, 2_000_000)));
    random_phase(250, 0);
    base = 64'd5000;
    for (int unsigned k = 0; k < DEPTH + 6; k++) begin
      send_item(mk_item(64'd5000, 64'd5000 + 4 * DEPTH, base + 3 * k, 1'b1,
                        k == DEPTH + 5));
    end
    overflow_windows++;
    random_phase(20, 0);
    drain();

    $display("Run covered %0d items in %0d windows, %0d results checked, %0d over capacity",
             items_sent, sb.windows, sb.verdicts, overflow_windows);
    $display("Verdicts ok/invalid/empty/prefix/suffix/gap: %0d/%0d/%0d/%0d/%0d/%0d",
             sb.reason_seen[0], sb.reason_seen[1], sb.reason_seen[2],
             sb.reason_seen[3], sb.reason_seen[4], sb.reason_seen[5]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", sb.errors,
               sb.pending_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
